// File: sv/b2b_pkg.sv
// ----------------------------------------------------------------------------
// b2b_pkg - shared types and constants for the BLAKE2b engine
// Word structs, IV, permutation schedule and the G function helpers.
// ----------------------------------------------------------------------------
package b2b_pkg;

   typedef struct packed {
      logic [63:0] msg_word;
      logic [3:0]  byte_count;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_word;
      logic [3:0]  digest_bytes;
      logic        last_out;
   } rsp_type;

   // queue entry between front and back
   typedef enum logic [1:0] {
      OP_DATA  = 2'd0,
      OP_LAST  = 2'd1,
      OP_FINAL = 2'd2
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [63:0] word;
      logic [3:0]  nbytes;
   } cmd_type;

   localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;

   function automatic logic [63:0] iv_word(input logic [2:0] i);
      logic [63:0] r;
      case (i)
         3'd0: r = 64'h6A09E667F3BCC908;
         3'd1: r = 64'hBB67AE8584CAA73B;
         3'd2: r = 64'h3C6EF372FE94F82B;
         3'd3: r = 64'hA54FF53A5F1D36F1;
         3'd4: r = 64'h510E527FADE682D1;
         3'd5: r = 64'h9B05688C2B3E6C1F;
         3'd6: r = 64'h1F83D9ABFB41BD6B;
         default: r = 64'h5BE0CD19137E2179;
      endcase
      return r;
   endfunction

   // sigma row packed as 16 nibbles, entry 0 in the low nibble
   function automatic logic [63:0] sigma_row(input logic [3:0] r);
      logic [63:0] s;
      case (r)
         4'd0: s = 64'hFEDCBA9876543210;
         4'd1: s = 64'h357B20C16DF984AE;
         4'd2: s = 64'h491763EADF250C8B;
         4'd3: s = 64'h8F04A562EBCD1397;
         4'd4: s = 64'hD386CB1EFA427509;
         4'd5: s = 64'h91EF57D438B0A6C2;
         4'd6: s = 64'hB8293670A4DEF15C;
         4'd7: s = 64'hA2684F05931CE7BD;
         4'd8: s = 64'h5A417D2C803B9EF6;
         default: s = 64'h0DC3E9BF5167482A;
      endcase
      // note: rows written high nibble first, see nibble helper
      return s;
   endfunction

   function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
      logic [63:0] s;
      s = sigma_row(r);
      return s[k*4 +: 4];
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   typedef struct packed {
      logic [63:0] a, b, c, d;
   } quad_type;

   // half of G: one add/xor/rotate pass
   function automatic quad_type g_half(input quad_type q, input logic [63:0] m,
                                       input logic second);
      quad_type o;
      o   = q;
      o.a = o.a + o.b + m;
      o.d = second ? rotr(o.d ^ o.a, 16) : rotr(o.d ^ o.a, 32);
      o.c = o.c + o.d;
      o.b = second ? rotr(o.b ^ o.c, 63) : rotr(o.b ^ o.c, 24);
      return o;
   endfunction

endpackage

// File: sv/blake2b_hash_top.sv
// ----------------------------------------------------------------------------
// blake2b_hash_top - unkeyed BLAKE2b hash engine
// Streams 64-bit message words in, digest words out.
// ----------------------------------------------------------------------------
// A word is queued by the front, and sixteen words fill a block. A block
// compression is done by four shared G half-step units doing one half column
// or diagonal pass per cycle. The core takes no new word while it compresses
// a block or sends out the digest words. The digest length register
// (1..64 bytes) may only be written while idle; it restarts the chain.
module blake2b_hash_top #(
   parameter int ROUNDS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b2b_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b2b_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [6:0]        csr_data
);
   import b2b_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   assign csr_ready = 1'b1;

   b2b_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   b2b_core #(.ROUNDS(ROUNDS)) u_core (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .cfg_we(csr_valid), .cfg_len(csr_data),
      .rsp_valid, .rsp_stall, .rsp_data
   );

endmodule

// File: sv/b2b_front.sv
// ----------------------------------------------------------------------------
// b2b_front - input word classifier
// Clamps byte counts, masks partial words and tags each word for the core.
// ----------------------------------------------------------------------------
module b2b_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  b2b_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output b2b_pkg::cmd_type  cmd_data
);
   import b2b_pkg::*;

   localparam int DEPTH = 2;

   cmd_type    q_ff [DEPTH];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   logic       push, pop;
   cmd_type    c;
   logic [3:0] bc;

   assign req_stall = (cnt_ff == 2'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rd_ff];

   always_comb begin
      bc = (req_data.byte_count > 4'd8) ? 4'd8 : req_data.byte_count;
      c.word = req_data.msg_word;
      if (!req_data.last_word) begin
         c.op     = OP_DATA;
         c.nbytes = 4'd8;
      end else begin
         c.op     = OP_LAST;
         c.nbytes = bc;
         if (bc < 4'd8) c.word = req_data.msg_word & ((64'd1 << {bc, 3'b000}) - 64'd1);
      end
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= c;
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(DEPTH))
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0) |-> !pop) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");

endmodule

// File: sv/b2b_core.sv
// ----------------------------------------------------------------------------
// b2b_core - block assembly, compression and digest output
// Four G half-step units work one half of a column or diagonal step per cycle.
// ----------------------------------------------------------------------------
module b2b_core #(
   parameter int ROUNDS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  b2b_pkg::cmd_type  cmd_data,
   input  logic              cfg_we,
   input  logic [6:0]        cfg_len,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output b2b_pkg::rsp_type  rsp_data
);
   import b2b_pkg::*;

   localparam int RW = $clog2(ROUNDS);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_INIT = 5'b00010,
      S_RUN  = 5'b00100,
      S_FOLD = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type    st_ff, st_in;
   logic [6:0]   len_ff;
   logic [63:0]  h_ff [8];
   logic [63:0]  m_ff [16];
   logic [63:0]  v_ff [16];
   logic [63:0]  cnt_lo_ff, cnt_hi_ff;
   logic [3:0]   widx_ff;
   logic         pend_ff;
   logic         fin_ff;       // current compression is final
   logic         emit_ff;      // digest after this compression
   cmd_type      hold_ff;      // word to store after a pending block
   logic         hold_v_ff;
   logic [RW-1:0] rnd_ff;
   logic [1:0]   ph_ff;        // column/diag, half
   logic [2:0]   ok_ff;
   logic [6:0]   elen;
   logic [6:0]   nlen;         // length used when the chain restarts
   logic [3:0]   srow;
   quad_type     qi [4], qo [4];
   logic [3:0]   ia [4], ib [4], ic [4], id [4];
   logic         take;

   always_comb begin
      elen = (cfg_len == 7'd0) ? 7'd1 : (cfg_len > 7'd64) ? 7'd64 : cfg_len;
      nlen = reset ? 7'd64 : (cfg_we ? elen : len_ff);
   end

   assign cmd_ready = (st_ff == S_IDLE) && !cfg_we;
   assign take      = cmd_valid && cmd_ready;

   // lane mapping for column (ph[1]=0) or diagonal step
   always_comb begin
      // sigma row wraps after ten rounds
      srow = (rnd_ff >= RW'(10)) ? 4'(rnd_ff - RW'(10)) : 4'(rnd_ff);
      for (int j = 0; j < 4; j++) begin
         ia[j] = 4'(j);
         ib[j] = ph_ff[1] ? 4'(4 + ((j + 1) % 4)) : 4'(4 + j);
         ic[j] = ph_ff[1] ? 4'(8 + ((j + 2) % 4)) : 4'(8 + j);
         id[j] = ph_ff[1] ? 4'(12 + ((j + 3) % 4)) : 4'(12 + j);
         qi[j] = '{v_ff[ia[j]], v_ff[ib[j]], v_ff[ic[j]], v_ff[id[j]]};
         qo[j] = g_half(qi[j],
                        m_ff[sigma(srow, {ph_ff[1], 2'(j), ph_ff[0]})], ph_ff[0]);
      end
   end

   logic [6:0] rem;
   always_comb begin
      rem = len_ff - {1'b0, ok_ff, 3'b000};
      rsp_data.digest_bytes = (rem > 7'd8) ? 4'd8 : rem[3:0];
      rsp_data.digest_word  = h_ff[ok_ff];
      if (rem < 7'd8) rsp_data.digest_word = h_ff[ok_ff] & ((64'd1 << {rem[2:0], 3'b000}) - 64'd1);
      rsp_data.last_out = (rem <= 7'd8);
   end
   assign rsp_valid = (st_ff == S_OUT);

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         S_IDLE: if (take && (cmd_data.op == OP_LAST || pend_ff)) st_in = S_INIT;
         S_INIT: st_in = S_RUN;
         S_RUN:  if (rnd_ff == RW'(ROUNDS - 1) && ph_ff == 2'd3) st_in = S_FOLD;
         S_FOLD: st_in = hold_v_ff ? (hold_ff.op == OP_LAST ? S_INIT : S_IDLE)
                                   : (emit_ff ? S_OUT : S_IDLE);
         S_OUT:  if (!rsp_stall && rsp_data.last_out) st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         S_IDLE: if (take) begin
            if (pend_ff && !(cmd_data.op == OP_LAST && cmd_data.nbytes == 4'd0)) begin
               // flush pending block first, keep word for later
               hold_ff   <= cmd_data;
               hold_v_ff <= 1'b1;
               fin_ff    <= 1'b0;
               emit_ff   <= 1'b0;
            end else if (pend_ff) begin
               fin_ff  <= 1'b1;
               emit_ff <= 1'b1;
            end else begin
               m_ff[widx_ff] <= cmd_data.word;
               {cnt_hi_ff, cnt_lo_ff} <= {cnt_hi_ff, cnt_lo_ff} + 128'(cmd_data.nbytes);
               if (cmd_data.op == OP_LAST) begin
                  for (int i = 0; i < 16; i++)
                     if (4'(i) > widx_ff) m_ff[i] <= '0;
                  fin_ff  <= 1'b1;
                  emit_ff <= 1'b1;
               end else begin
                  widx_ff <= widx_ff + 4'd1;
                  if (widx_ff == 4'd15) pend_ff <= 1'b1;
               end
            end
         end
         S_INIT: begin
            for (int i = 0; i < 8; i++) begin
               v_ff[i]   <= h_ff[i];
               v_ff[i+8] <= iv_word(3'(i));
            end
            v_ff[12] <= iv_word(3'd4) ^ cnt_lo_ff;
            v_ff[13] <= iv_word(3'd5) ^ cnt_hi_ff;
            v_ff[14] <= fin_ff ? ~iv_word(3'd6) : iv_word(3'd6);
            rnd_ff <= '0;
            ph_ff  <= 2'd0;
            pend_ff <= 1'b0;
         end
         S_RUN: begin
            for (int j = 0; j < 4; j++) begin
               v_ff[ia[j]] <= qo[j].a;
               v_ff[ib[j]] <= qo[j].b;
               v_ff[ic[j]] <= qo[j].c;
               v_ff[id[j]] <= qo[j].d;
            end
            ph_ff <= ph_ff + 2'd1;
            if (ph_ff == 2'd3) rnd_ff <= rnd_ff + RW'(1);
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] ^ v_ff[i] ^ v_ff[i+8];
            ok_ff <= '0;
            widx_ff <= '0;
            if (hold_v_ff) begin
               hold_v_ff <= 1'b0;
               m_ff[0] <= hold_ff.word;
               {cnt_hi_ff, cnt_lo_ff} <= {cnt_hi_ff, cnt_lo_ff} + 128'(hold_ff.nbytes);
               if (hold_ff.op == OP_LAST) begin
                  for (int i = 1; i < 16; i++) m_ff[i] <= '0;
                  fin_ff  <= 1'b1;
                  emit_ff <= 1'b1;
               end else widx_ff <= 4'd1;
            end
         end
         S_OUT: if (!rsp_stall) ok_ff <= ok_ff + 3'd1;
         default: ;
      endcase
      if (reset || cfg_we || (st_ff == S_OUT && !rsp_stall && rsp_data.last_out)) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= iv_word(3'(i));
         h_ff[0]   <= iv_word(3'd0) ^ PARAM_BASE ^ 64'(nlen);
         len_ff    <= nlen;
         cnt_lo_ff <= '0;
         cnt_hi_ff <= '0;
         widx_ff   <= '0;
         pend_ff   <= 1'b0;
         hold_v_ff <= 1'b0;
      end
      if (reset) st_ff <= S_IDLE;
      else       st_ff <= st_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(ok_ff)) else $error("digest index moved");
   assert property (@(posedge clock) disable iff (reset)
      st_ff == S_FOLD |-> $past(st_ff) == S_RUN) else $error("fold without rounds");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> len_ff > {1'b0, ok_ff, 3'b000}) else $error("digest overrun");

endmodule
